// ----- hw/rtl/bbp_pkg.sv -----
// bbp_pkg: shared types, constants and reset values for the bgra32 to bgr24 packer
// used by bbp_cfg, bbp_core, bbp_outq and bgra32_to_bgr24_flip_packer
// no dependencies
package bbp_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int ADDR_BITS_DEF  = 26;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_STRIDE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PITCH = 2'd3;

  localparam logic [12:0] RST_WIDTH  = 13'd640;
  localparam logic [12:0] RST_HEIGHT = 13'd480;
  localparam logic [14:0] RST_STRIDE = 15'd1920;
  localparam logic [15:0] RST_PITCH  = 16'd2560;

  // (height - 1) * stride for the reset configuration
  localparam logic [31:0] RST_FIRST_BASE = 32'((480 - 1) * 1920);

  localparam logic [14:0] PIX_BYTES = 15'd3;

  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic        ok;
    logic        pad_zero;
    logic [14:0] pad;
    logic [12:0] width;
    logic [12:0] height;
    logic [14:0] stride;
  } cfg_t;

  typedef struct packed {
    logic        write_valid;
    logic [25:0] write_address;
    logic [23:0] write_data;
    logic [14:0] byte_count;
    logic        row_end;
    logic        frame_end;
    logic        config_error;
    logic        last_of_item;
  } res_t;

endpackage

// ----- hw/rtl/bbp_cfg.sv -----
// bbp_cfg: configuration registers, validity check and derived row values
// depends on bbp_pkg
module bbp_cfg #(
  parameter int MAX_WIDTH  = bbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbp_pkg::MAX_HEIGHT_DEF,
  parameter int ADDR_BITS  = bbp_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bbp_pkg::cfg_t                    cfg_o,
  output logic                             restart,
  output logic [ADDR_BITS-1:0]             base_nxt,
  output logic [ADDR_BITS-1:0]             first_base
);

  logic [12:0] width_r, width_nxt;
  logic [12:0] height_r, height_nxt;
  logic [14:0] stride_r, stride_nxt;
  logic [15:0] pitch_r, pitch_nxt;
  logic        ok_r, ok_nxt;
  logic        pad_zero_r, pad_zero_nxt;
  logic [14:0] pad_r, pad_nxt;
  logic [ADDR_BITS-1:0] first_base_r;

  logic [15:0] three_w;
  logic [15:0] min_stride;
  logic [15:0] stride_ext;
  logic [12:0] h_m1;
  logic [27:0] prod;
  logic [31:0] prod32;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    stride_nxt = stride_r;
    pitch_nxt  = pitch_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bbp_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_data[12:0];
        bbp_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_data[12:0];
        bbp_pkg::REG_DEST_STRIDE:  stride_nxt = cfg_data[14:0];
        bbp_pkg::REG_SOURCE_PITCH: pitch_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  // minimum stride is 3*width rounded up to a multiple of four bytes
  always_comb begin
    three_w      = {2'b00, width_nxt, 1'b0} + {3'b000, width_nxt};
    min_stride   = (three_w + 16'd3) & ~16'd3;
    stride_ext   = {1'b0, stride_nxt};
    ok_nxt       = (width_nxt != 13'd0) && (height_nxt != 13'd0) &&
                   ({3'b000, width_nxt} <= 16'(MAX_WIDTH)) &&
                   ({3'b000, height_nxt} <= 16'(MAX_HEIGHT)) &&
                   (pitch_nxt != 16'd0) && (pitch_nxt >= {1'b0, width_nxt, 2'b00}) &&
                   (stride_ext >= min_stride);
    pad_nxt      = 15'(stride_ext - three_w);
    pad_zero_nxt = (stride_ext == three_w);
    h_m1         = (height_nxt == 13'd0) ? 13'd0 : height_nxt - 13'd1;
    prod         = 28'(h_m1) * 28'(stride_nxt);
    prod32       = 32'(prod);
    base_nxt     = prod32[ADDR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= bbp_pkg::RST_WIDTH;
      height_r     <= bbp_pkg::RST_HEIGHT;
      stride_r     <= bbp_pkg::RST_STRIDE;
      pitch_r      <= bbp_pkg::RST_PITCH;
      ok_r         <= 1'b1;
      pad_zero_r   <= 1'b1;
      pad_r        <= 15'd0;
      first_base_r <= bbp_pkg::RST_FIRST_BASE[ADDR_BITS-1:0];
    end else begin
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      stride_r     <= stride_nxt;
      pitch_r      <= pitch_nxt;
      ok_r         <= ok_nxt;
      pad_zero_r   <= pad_zero_nxt;
      pad_r        <= pad_nxt;
      first_base_r <= base_nxt;
    end
  end

  assign cfg_o.ok       = ok_r;
  assign cfg_o.pad_zero = pad_zero_r;
  assign cfg_o.pad      = pad_r;
  assign cfg_o.width    = width_r;
  assign cfg_o.height   = height_r;
  assign cfg_o.stride   = stride_r;
  assign restart        = cfg_we;
  assign first_base     = first_base_r;

endmodule

// ----- hw/rtl/bbp_core.sv -----
// bbp_core: column/row counters, bottom-up address tracking and result building
// depends on bbp_pkg; configuration comes from bbp_cfg
module bbp_core #(
  parameter int MAX_WIDTH  = bbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbp_pkg::MAX_HEIGHT_DEF,
  parameter int ADDR_BITS  = bbp_pkg::ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [31:0]          pixel_word,
  input  bbp_pkg::cfg_t        cfg,
  input  logic                 restart,
  input  logic [ADDR_BITS-1:0] base_nxt,
  input  logic [ADDR_BITS-1:0] first_base,
  output bbp_pkg::res_t        res0,
  output bbp_pkg::res_t        res1,
  output logic                 two
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [ADDR_BITS-1:0] row_base_r, row_base_nxt;
  logic [ADDR_BITS-1:0] pix_addr_r, pix_addr_nxt;

  logic [15:0]          col_inc;
  logic [15:0]          row_inc;
  logic                 last_col;
  logic                 last_row;
  logic [ADDR_BITS-1:0] fill_addr;
  logic [ADDR_BITS-1:0] prev_base;
  logic [31:0]          pix_addr32;
  logic [31:0]          fill_addr32;

  always_comb begin
    col_inc     = 16'(col_r) + 16'd1;
    row_inc     = 16'(row_r) + 16'd1;
    last_col    = col_inc >= {3'b000, cfg.width};
    last_row    = row_inc >= {3'b000, cfg.height};
    fill_addr   = pix_addr_r + ADDR_BITS'(bbp_pkg::PIX_BYTES);
    prev_base   = row_base_r - ADDR_BITS'(cfg.stride);
    pix_addr32  = 32'(pix_addr_r);
    fill_addr32 = 32'(fill_addr);
  end

  // pixel write, or the error result when the configuration is bad
  always_comb begin
    res0 = '0;
    if (!cfg.ok) begin
      res0.config_error = 1'b1;
      res0.last_of_item = 1'b1;
    end else begin
      res0.write_valid   = 1'b1;
      res0.write_address = pix_addr32[25:0];
      res0.write_data    = pixel_word[23:0];
      res0.byte_count    = bbp_pkg::PIX_BYTES;
      res0.row_end       = last_col && cfg.pad_zero;
      res0.frame_end     = last_col && cfg.pad_zero && last_row;
      res0.last_of_item  = !last_col || cfg.pad_zero;
    end
  end

  // padding fill after the last pixel of a row
  always_comb begin
    res1               = '0;
    res1.write_valid   = 1'b1;
    res1.write_address = fill_addr32[25:0];
    res1.byte_count    = cfg.pad;
    res1.row_end       = 1'b1;
    res1.frame_end     = last_row;
    res1.last_of_item  = 1'b1;
    two                = cfg.ok && last_col && !cfg.pad_zero;
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    pix_addr_nxt = pix_addr_r;
    if (restart) begin
      col_nxt      = '0;
      row_nxt      = '0;
      row_base_nxt = base_nxt;
      pix_addr_nxt = base_nxt;
    end else if (accept && cfg.ok) begin
      if (!last_col) begin
        col_nxt      = COL_W'(col_inc);
        pix_addr_nxt = fill_addr;
      end else begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt      = '0;
          row_base_nxt = first_base;
          pix_addr_nxt = first_base;
        end else begin
          row_nxt      = ROW_W'(row_inc);
          row_base_nxt = prev_base;
          pix_addr_nxt = prev_base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      row_base_r <= bbp_pkg::RST_FIRST_BASE[ADDR_BITS-1:0];
      pix_addr_r <= bbp_pkg::RST_FIRST_BASE[ADDR_BITS-1:0];
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      row_base_r <= row_base_nxt;
      pix_addr_r <= pix_addr_nxt;
    end
  end

endmodule

// ----- hw/rtl/bbp_outq.sv -----
// bbp_outq: small result queue taking up to two results a cycle, one out
// depends on bbp_pkg
module bbp_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          push_two,
  input  bbp_pkg::res_t res0,
  input  bbp_pkg::res_t res1,
  input  logic          pop,
  output logic          not_empty,
  output logic          full,
  output bbp_pkg::res_t head
);

  localparam int PTR_W = $clog2(bbp_pkg::OUTQ_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  bbp_pkg::res_t    q_r [bbp_pkg::OUTQ_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] tail_p1;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_push;

  always_comb begin
    tail_p1   = tail_r + PTR_W'(1);
    n_push    = push ? (push_two ? CNT_W'(2) : CNT_W'(1)) : '0;
    tail_nxt  = tail_r + PTR_W'(n_push);
    head_nxt  = pop ? head_r + PTR_W'(1) : head_r;
    count_nxt = count_r + n_push - (pop ? CNT_W'(1) : CNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r] <= res0;
    end
    if (push && push_two) begin
      q_r[tail_p1] <= res1;
    end
  end

  // room for two results is kept whenever a request may be taken
  assign full      = count_r > CNT_W'(bbp_pkg::OUTQ_DEPTH - 2);
  assign not_empty = count_r != '0;
  assign head      = q_r[head_r];

endmodule

// ----- hw/rtl/bgra32_to_bgr24_flip_packer.sv -----
// bgra32_to_bgr24_flip_packer: top level of the bgra32 to bottom-up bgr24 packer
// depends on bbp_pkg, bbp_cfg, bbp_core, bbp_outq
//
// Usage:
//   in_*  : one 32-bit bgra pixel per request, top-down, left to right
//   out_* : destination writes (3-byte bgr pixel, or a zero fill for row padding)
//           or a single config_error result per pixel when the setup is invalid
//   cfg_* : register writes (0 width, 1 height, 2 stride, 3 pitch), each one
//           restarts the frame; write only while no request is in flight
// Output path: a pixel's results are written into the result queue when it is taken
// Throughput: one pixel per cycle while in_stall is low; the last pixel of a padded row makes two
//   results, so a row of w pixels gives w+1 results. A four-entry result
//   queue absorbs this and raises in_stall when fewer than two slots are free.
// Reset: synchronous active-low; registers return to 640x480, stride 1920,
//   pitch 2560, and counters start at the top row of the frame.
// Receiver stall: results wait in the queue with out_valid held; the input
//   keeps accepting until the queue is nearly full.
module bgra32_to_bgr24_flip_packer #(
  parameter int MAX_WIDTH  = bbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbp_pkg::MAX_HEIGHT_DEF,
  parameter int ADDR_BITS  = bbp_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_pixel_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_write_valid,
  output logic [25:0]                    out_write_address,
  output logic [23:0]                    out_write_data,
  output logic [14:0]                    out_byte_count,
  output logic                           out_row_end,
  output logic                           out_frame_end,
  output logic                           out_config_error,
  output logic                           out_last_of_item,
  input  logic                           cfg_we,
  input  logic [bbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbp_pkg::CFG_DATA_W-1:0] cfg_data
);

  bbp_pkg::cfg_t        cfg;
  bbp_pkg::res_t        res0;
  bbp_pkg::res_t        res1;
  bbp_pkg::res_t        head;
  logic                 restart;
  logic [ADDR_BITS-1:0] base_nxt;
  logic [ADDR_BITS-1:0] first_base;
  logic                 accept;
  logic                 two;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 pop;

  assign accept    = in_valid && !q_full;
  assign pop       = q_not_empty && !out_stall;
  assign in_stall  = q_full;
  assign out_valid = q_not_empty;

  bbp_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_BITS  (ADDR_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_o      (cfg),
    .restart    (restart),
    .base_nxt   (base_nxt),
    .first_base (first_base)
  );

  bbp_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_BITS  (ADDR_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .pixel_word (in_pixel_word),
    .cfg        (cfg),
    .restart    (restart),
    .base_nxt   (base_nxt),
    .first_base (first_base),
    .res0       (res0),
    .res1       (res1),
    .two        (two)
  );

  bbp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_two  (two),
    .res0      (res0),
    .res1      (res1),
    .pop       (pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head      (head)
  );

  assign out_write_valid   = head.write_valid;
  assign out_write_address = head.write_address;
  assign out_write_data    = head.write_data;
  assign out_byte_count    = head.byte_count;
  assign out_row_end       = head.row_end;
  assign out_frame_end     = head.frame_end;
  assign out_config_error  = head.config_error;
  assign out_last_of_item  = head.last_of_item;

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg.ok) |-> !two)
    else $error("error result paired with a fill");

  a_fill_split: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && two) |-> (!res0.last_of_item && !res0.row_end && res1.row_end))
    else $error("row end flags misplaced around fill");

  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_config_error) |-> !out_write_valid)
    else $error("config error result carries a write");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("results present right after reset");

endmodule
